// ===== sv/accumulator_machine_execute_defines.svh =====
// ============================================================================
// Assertion macros for the accumulator machine
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH

// Expression holds at every edge out of reset.
`define ACCU_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ACCU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ACCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/accu_pkg.sv =====
// ============================================================================
// Accumulator machine package
// Types, codes and constants shared by the front end, queue and back end.
// ============================================================================
package accu_pkg;

    localparam int MEM_WORDS  = 100;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int MAG_W      = 14;
    localparam int DIV_STEPS  = MAG_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic signed [14:0] WORD_MAX = 15'sd9999;
    localparam logic signed [14:0] WORD_MIN = -15'sd9999;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_STORE = 3'd3,
        CMD_ADD   = 3'd4,
        CMD_SUB   = 3'd5,
        CMD_DIV   = 3'd6,
        CMD_MUL   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    // Classified instruction as held in the queue
    typedef struct packed {
        cmd_t               cmd;
        logic [6:0]         address;
        logic signed [14:0] value;
        logic               flagged;
        status_t            pre_status;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_MUL,
        BK_DIV,
        BK_DIVEND,
        BK_DONE
    } bk_state_t;

endpackage

// ===== sv/accu_front.sv =====
// ============================================================================
// Accumulator machine front end
// Takes instruction beats and flags bad addresses and out-of-range values.
// ============================================================================
module accu_front
    import accu_pkg::*;
(
    input  logic        push,
    output logic        full,
    input  logic [2:0]  cmd,
    input  logic [6:0]  address,
    input  logic signed [14:0] value,
    input  q_stat_t     q_stat,
    output logic        q_wr_en,
    output op_t         q_wr_data
);

    logic addr_ok;
    logic val_ok;

    assign addr_ok = (32'(address) < 32'(MEM_WORDS));
    assign val_ok  = (value >= WORD_MIN) && (value <= WORD_MAX);

    assign full    = q_stat.full;
    assign q_wr_en = push && !q_stat.full;

    always_comb
    begin
        q_wr_data.cmd        = cmd_t'(cmd);
        q_wr_data.address    = address;
        q_wr_data.value      = value;
        q_wr_data.flagged    = !(addr_ok && val_ok);
        // address check takes priority over the value check
        if (!addr_ok)
        begin
            q_wr_data.pre_status = ST_UNKNOWN;
        end
        else if (!val_ok)
        begin
            q_wr_data.pre_status = ST_OVERFLOW;
        end
        else
        begin
            q_wr_data.pre_status = ST_OK;
        end
    end

endmodule

// ===== sv/accu_fifo.sv =====
// ============================================================================
// Accumulator machine instruction queue
// Short register queue between the front end and the back end.
// ============================================================================
`include "accumulator_machine_execute_defines.svh"

module accu_fifo
    import accu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  op_t     wr_data,
    input  logic    rd_en,
    output op_t     rd_data,
    output q_stat_t stat
);

    op_t               ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_data    = ent_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr_en ? ptr_inc(wptr_reg) : wptr_reg;
        rptr_next = rd_en ? ptr_inc(rptr_reg) : rptr_reg;
        cnt_next  = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg[wptr_reg] <= wr_data;
        end
    end

    `ACCU_ASSERT_IMP(a_no_write_full, wr_en, !stat.full, "queue written while full")
    `ACCU_ASSERT_IMP(a_no_read_empty, rd_en, !stat.empty, "queue read while empty")
    `ACCU_ASSERT_HOLDS(a_cnt_bound, cnt_reg <= QCNT_W'(QDEPTH), "queue count beyond depth")

endmodule

// ===== sv/accu_back.sv =====
// ============================================================================
// Accumulator machine back end
// Word memory, accumulator, sequencer, serial divider and result slot.
// ============================================================================
`include "accumulator_machine_execute_defines.svh"

module accu_back
    import accu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_stat_t            q_stat,
    input  op_t                q_head,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [14:0] read_data,
    output logic signed [14:0] accumulator,
    output logic [1:0]         status
);

    bk_state_t state_reg, state_next;

    // word memory with one valid bit per word; unwritten words read as zero
    logic signed [14:0] mem_array [MEM_WORDS];
    logic [MEM_WORDS-1:0] valid_reg;
    logic signed [14:0] rdata_reg;
    logic               rvalid_reg;
    logic               mem_rd_en;
    logic               mem_wr_en;
    logic signed [14:0] mem_wdata;
    logic [MEM_AW-1:0]  rd_idx;
    logic [MEM_AW-1:0]  wr_idx;
    logic signed [14:0] mword;

    op_t                op_reg, op_next;
    logic signed [14:0] acc_reg, acc_next;
    logic signed [29:0] prod_reg, prod_next;
    logic [MAG_W-1:0]   rem_reg, rem_next;
    logic [MAG_W-1:0]   quo_reg, quo_next;
    logic [MAG_W-1:0]   dvs_reg, dvs_next;
    logic               neg_reg, neg_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic signed [14:0] res_rd_reg, res_rd_next;
    status_t            res_st_reg, res_st_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [14:0] out_rd_reg, out_rd_next;
    logic signed [14:0] out_acc_reg, out_acc_next;
    status_t            out_st_reg, out_st_next;

    logic pop_ok;
    logic slot_free;

    assign pop_ok    = pop && out_valid_reg;
    assign slot_free = !out_valid_reg || pop_ok;
    assign rd_idx    = MEM_AW'(q_head.address);
    assign wr_idx    = MEM_AW'(op_reg.address);
    assign mword     = rvalid_reg ? rdata_reg : '0;

    assign empty       = !out_valid_reg;
    assign read_data   = out_rd_reg;
    assign accumulator = out_acc_reg;
    assign status      = out_st_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!op_reg.flagged && op_reg.cmd == CMD_MUL)
                begin
                    state_next = BK_MUL;
                end
                else if (!op_reg.flagged && op_reg.cmd == CMD_DIV && mword != '0)
                begin
                    state_next = BK_DIV;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DONE;
            end
            BK_DIV:
            begin
                if (cnt_reg == DCNT_W'(1))
                begin
                    state_next = BK_DIVEND;
                end
            end
            BK_DIVEND:
            begin
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath and strobes
    always_comb
    begin
        logic signed [15:0] sum;
        logic [MAG_W:0]     rem_sh;
        logic               ge;
        logic signed [14:0] qs;

        op_next   = op_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        res_rd_next = res_rd_reg;
        res_st_next = res_st_reg;
        out_valid_next = out_valid_reg && !pop_ok;
        out_rd_next  = out_rd_reg;
        out_acc_next = out_acc_reg;
        out_st_next  = out_st_reg;
        q_pop     = 1'b0;
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        mem_wdata = op_reg.value;
        sum    = '0;
        rem_sh = '0;
        ge     = 1'b0;
        qs     = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_head;
                    mem_rd_en = !q_head.flagged;
                end
            end
            BK_EXEC:
            begin
                res_rd_next = '0;
                res_st_next = ST_OK;
                if (op_reg.flagged)
                begin
                    res_st_next = op_reg.pre_status;
                end
                else
                begin
                    case (op_reg.cmd)
                        CMD_WRITE:
                        begin
                            mem_wr_en = 1'b1;
                            mem_wdata = op_reg.value;
                        end
                        CMD_READ:
                        begin
                            res_rd_next = mword;
                        end
                        CMD_LOAD:
                        begin
                            acc_next = mword;
                        end
                        CMD_STORE:
                        begin
                            mem_wr_en = 1'b1;
                            mem_wdata = acc_reg;
                        end
                        CMD_ADD, CMD_SUB:
                        begin
                            if (op_reg.cmd == CMD_ADD)
                            begin
                                sum = 16'(acc_reg) + 16'(mword);
                            end
                            else
                            begin
                                sum = 16'(acc_reg) - 16'(mword);
                            end
                            if (sum >= 16'(WORD_MIN) && sum <= 16'(WORD_MAX))
                            begin
                                acc_next = 15'(sum);
                            end
                            else
                            begin
                                res_st_next = ST_OVERFLOW;
                            end
                        end
                        CMD_MUL:
                        begin
                            prod_next = 30'(acc_reg) * 30'(mword);
                        end
                        CMD_DIV:
                        begin
                            if (mword == '0)
                            begin
                                res_st_next = ST_DIVZERO;
                            end
                            else
                            begin
                                quo_next = acc_reg[14] ? MAG_W'(-acc_reg) : acc_reg[MAG_W-1:0];
                                dvs_next = mword[14] ? MAG_W'(-mword) : mword[MAG_W-1:0];
                                rem_next = '0;
                                neg_next = acc_reg[14] ^ mword[14];
                                cnt_next = DCNT_W'(DIV_STEPS);
                            end
                        end
                        default:
                        begin
                            res_st_next = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            BK_MUL:
            begin
                if (prod_reg >= 30'(WORD_MIN) && prod_reg <= 30'(WORD_MAX))
                begin
                    acc_next = 15'(prod_reg);
                end
                else
                begin
                    res_st_next = ST_OVERFLOW;
                end
            end
            BK_DIV:
            begin
                // restoring step, one quotient bit a cycle
                rem_sh   = {rem_reg, quo_reg[MAG_W-1]};
                ge       = (rem_sh >= {1'b0, dvs_reg});
                rem_next = ge ? MAG_W'(rem_sh - {1'b0, dvs_reg}) : MAG_W'(rem_sh);
                quo_next = {quo_reg[MAG_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            BK_DIVEND:
            begin
                qs       = signed'({1'b0, quo_reg});
                acc_next = neg_reg ? -qs : qs;
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = res_rd_reg;
                    out_acc_next   = acc_reg;
                    out_st_next    = res_st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (mem_wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        neg_reg     <= neg_next;
        cnt_reg     <= cnt_next;
        res_rd_reg  <= res_rd_next;
        res_st_reg  <= res_st_next;
        out_rd_reg  <= out_rd_next;
        out_acc_reg <= out_acc_next;
        out_st_reg  <= out_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem_array[wr_idx] <= mem_wdata;
        end
        if (mem_rd_en)
        begin
            rdata_reg  <= mem_array[rd_idx];
            rvalid_reg <= valid_reg[rd_idx];
        end
    end

    `ACCU_ASSERT_HOLDS(a_acc_range, acc_reg >= WORD_MIN && acc_reg <= WORD_MAX, "acc out of range")
    `ACCU_ASSERT_IMP(a_div_cnt, state_reg == BK_DIV, cnt_reg != '0, "divider ran past last step")
    `ACCU_ASSERT_NEXT(a_done_loads, state_reg == BK_DONE && !out_valid_reg, out_valid_reg, "result slot not loaded")
    `ACCU_ASSERT_IMP(a_wr_clean, mem_wr_en, !op_reg.flagged && state_reg == BK_EXEC, "flagged op wrote memory")

endmodule

// ===== sv/accumulator_machine_execute.sv =====
// ============================================================================
// Accumulator machine execute unit
// Decimal-word accumulator machine, one instruction per beat, 100-word memory.
// ============================================================================
// Each input beat is one instruction (write, read, load, store, add, subtract,
// divide, multiply) and gives exactly one result beat carrying the read word,
// the accumulator after the instruction and a status code. Items are worked
// one at a time by the back end: write, read, load, store, add, subtract,
// divide by a zero word and any flagged instruction pass straight from the
// execute step to the result slot, multiply goes through the registered 15x15
// multiplier and then a range check, and divide by a nonzero word runs the
// serial restoring divider that produces one quotient bit per cycle over 14
// magnitude bits.
// A two-beat instruction queue sits between the front end and the back end,
// and a single result register parts the back end from the result side, so
// instructions are taken while a result waits to be popped. Memory words
// read as zero until first written; there is no clearing pass after reset.
// ============================================================================
module accumulator_machine_execute
    import accu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // instruction side
    input  logic               push,
    output logic               full,
    input  logic [2:0]         cmd,
    input  logic [6:0]         address,
    input  logic signed [14:0] value,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic signed [14:0] read_data,
    output logic signed [14:0] accumulator,
    output logic [1:0]         status
);

    // front end to queue
    logic    q_wr_en;
    op_t     q_wr_data;
    // queue to back end
    logic    q_pop;
    op_t     q_head;
    q_stat_t q_stat;

    // classification: address and value range checks
    accu_front u_front (
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .address   (address),
        .value     (value),
        .q_stat    (q_stat),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    // decouples instruction intake from execution
    accu_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .stat    (q_stat)
    );

    // execution: memory, accumulator, multiplier, divider, result register
    accu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .read_data   (read_data),
        .accumulator (accumulator),
        .status      (status)
    );

endmodule
